/* hw/rtl/tun_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Shared widths and defaults for the face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int IN_W   = 16;  // vertex coordinate
  localparam int EDGE_W = 17;  // b - a, c - a
  localparam int PROD_W = 34;  // edge by edge product
  localparam int N_W    = 34;  // cross product component, signed
  localparam int MAG_W  = 33;  // magnitude of a cross product component
  localparam int SQ_W   = 66;  // square of a magnitude
  localparam int LEN_W  = 68;  // squared length, sum of three squares
  localparam int Q_W    = 15;  // result magnitude bits
  localparam int OUT_W  = 16;  // signed result component

  localparam int OUT_FRAC_BITS_DEF = 15;

  // Width of the residue in the root stages. It holds the scaled square of a
  // component and also any trial value, which stays below 2^99.
  function automatic int rem_width(input int f);
    int w;
    w = 2 * f + SQ_W;
    if (w < 99) w = 99;
    return w + 1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tun_cross.sv */
// ----------------------------------------------------------------------------
// Cross product stages
// Three register stages: edges, six partial products, then the components.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [tun_pkg::IN_W-1:0]  a_x,
  input  wire logic signed [tun_pkg::IN_W-1:0]  a_y,
  input  wire logic signed [tun_pkg::IN_W-1:0]  a_z,
  input  wire logic signed [tun_pkg::IN_W-1:0]  b_x,
  input  wire logic signed [tun_pkg::IN_W-1:0]  b_y,
  input  wire logic signed [tun_pkg::IN_W-1:0]  b_z,
  input  wire logic signed [tun_pkg::IN_W-1:0]  c_x,
  input  wire logic signed [tun_pkg::IN_W-1:0]  c_y,
  input  wire logic signed [tun_pkg::IN_W-1:0]  c_z,
  output logic signed [tun_pkg::N_W-1:0]        n_x,
  output logic signed [tun_pkg::N_W-1:0]        n_y,
  output logic signed [tun_pkg::N_W-1:0]        n_z
);

  logic signed [tun_pkg::EDGE_W-1:0] e_bx, e_by, e_bz, e_cx, e_cy, e_cz;
  logic signed [tun_pkg::PROD_W-1:0] p0, p1, p2, p3, p4, p5;

  always_ff @(posedge clk) begin
    if (en) begin
      e_bx <= tun_pkg::EDGE_W'(b_x) - tun_pkg::EDGE_W'(a_x);
      e_by <= tun_pkg::EDGE_W'(b_y) - tun_pkg::EDGE_W'(a_y);
      e_bz <= tun_pkg::EDGE_W'(b_z) - tun_pkg::EDGE_W'(a_z);
      e_cx <= tun_pkg::EDGE_W'(c_x) - tun_pkg::EDGE_W'(a_x);
      e_cy <= tun_pkg::EDGE_W'(c_y) - tun_pkg::EDGE_W'(a_y);
      e_cz <= tun_pkg::EDGE_W'(c_z) - tun_pkg::EDGE_W'(a_z);

      p0 <= e_by * e_cz;
      p1 <= e_bz * e_cy;
      p2 <= e_bz * e_cx;
      p3 <= e_bx * e_cz;
      p4 <= e_bx * e_cy;
      p5 <= e_by * e_cx;

      // Each difference is below 2^33 in magnitude, so it fits without growth.
      n_x <= p0 - p1;
      n_y <= p2 - p3;
      n_z <= p4 - p5;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tun_len.sv */
// ----------------------------------------------------------------------------
// Squared length stages
// Squares the component magnitudes, then sums them and scales each square
// into the residue that the root stages start from.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_len #(
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             en,
  input  wire logic signed [tun_pkg::N_W-1:0]                   n_x,
  input  wire logic signed [tun_pkg::N_W-1:0]                   n_y,
  input  wire logic signed [tun_pkg::N_W-1:0]                   n_z,
  output logic [tun_pkg::LEN_W-1:0]                             len2,
  output logic [tun_pkg::rem_width(OUT_FRAC_BITS)-1:0]          t_x,
  output logic [tun_pkg::rem_width(OUT_FRAC_BITS)-1:0]          t_y,
  output logic [tun_pkg::rem_width(OUT_FRAC_BITS)-1:0]          t_z,
  output logic [2:0]                                            sgn,
  output logic                                                  nondeg
);

  localparam int RW = tun_pkg::rem_width(OUT_FRAC_BITS);

  logic [tun_pkg::MAG_W-1:0] m_x, m_y, m_z;
  logic [tun_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [2:0]                sgn_s;
  logic                      nondeg_s;

  always_comb begin
    m_x = n_x[tun_pkg::N_W-1] ? tun_pkg::MAG_W'(-n_x) : tun_pkg::MAG_W'(n_x);
    m_y = n_y[tun_pkg::N_W-1] ? tun_pkg::MAG_W'(-n_y) : tun_pkg::MAG_W'(n_y);
    m_z = n_z[tun_pkg::N_W-1] ? tun_pkg::MAG_W'(-n_z) : tun_pkg::MAG_W'(n_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x     <= tun_pkg::SQ_W'(m_x) * tun_pkg::SQ_W'(m_x);
      sq_y     <= tun_pkg::SQ_W'(m_y) * tun_pkg::SQ_W'(m_y);
      sq_z     <= tun_pkg::SQ_W'(m_z) * tun_pkg::SQ_W'(m_z);
      sgn_s    <= {n_z[tun_pkg::N_W-1], n_y[tun_pkg::N_W-1], n_x[tun_pkg::N_W-1]};
      nondeg_s <= (n_x != '0) || (n_y != '0) || (n_z != '0);

      len2   <= tun_pkg::LEN_W'(sq_x) + tun_pkg::LEN_W'(sq_y) + tun_pkg::LEN_W'(sq_z);
      t_x    <= RW'(sq_x) << (2 * OUT_FRAC_BITS);
      t_y    <= RW'(sq_y) << (2 * OUT_FRAC_BITS);
      t_z    <= RW'(sq_z) << (2 * OUT_FRAC_BITS);
      sgn    <= sgn_s;
      nondeg <= nondeg_s;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tun_root.sv */
// ----------------------------------------------------------------------------
// Normalizing root lane
// Finds the largest q below 2^15 with q^2 * len2 <= t, one bit per stage.
// The residue t - q^2 * len2 and the product len2 * q are kept so that each
// stage needs only shifts, adds and one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_root #(
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        en,
  input  wire logic [tun_pkg::rem_width(OUT_FRAC_BITS)-1:0] t,
  input  wire logic [tun_pkg::LEN_W-1:0]                   len2,
  input  wire logic                                        sgn_in,
  output logic [tun_pkg::Q_W-1:0]                          q,
  output logic                                             sgn_out
);

  localparam int RW = tun_pkg::rem_width(OUT_FRAC_BITS);
  localparam int PW = tun_pkg::LEN_W + tun_pkg::Q_W + 1;
  localparam int NS = tun_pkg::Q_W;

  logic [RW-1:0]               r_st [0:NS];
  logic [PW-1:0]               p_st [0:NS];
  logic [tun_pkg::Q_W-1:0]     q_st [0:NS];
  logic [tun_pkg::LEN_W-1:0]   l_st [0:NS];
  logic                        s_st [0:NS];
  logic [RW-1:0]               d    [0:NS-1];
  logic                        ok   [0:NS-1];

  // Stage s decides bit NS-1-s. Trial cost: len2 * (2*q*2^b + 2^(2b)).
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      d[s]  = (RW'(p_st[s]) << (NS - s)) + (RW'(l_st[s]) << (2 * (NS - 1 - s)));
      ok[s] = d[s] <= r_st[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_st[0] <= t;
      p_st[0] <= '0;
      q_st[0] <= '0;
      l_st[0] <= len2;
      s_st[0] <= sgn_in;
      for (int s = 0; s < NS; s++) begin
        r_st[s+1] <= ok[s] ? r_st[s] - d[s] : r_st[s];
        p_st[s+1] <= ok[s] ? p_st[s] + (PW'(l_st[s]) << (NS - 1 - s)) : p_st[s];
        q_st[s+1] <= ok[s] ? q_st[s] | (tun_pkg::Q_W'(1) << (NS - 1 - s)) : q_st[s];
        l_st[s+1] <= l_st[s];
        s_st[s+1] <= s_st[s];
      end
    end
  end

  assign q       = q_st[NS];
  assign sgn_out = s_st[NS];

endmodule

`default_nettype wire

/* hw/rtl/triangle_unit_normal_unit.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of a triangle in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The slave channel takes one triangle per word: nine signed 16-bit vertex
// coordinates packed in s_tdata. The master channel gives one result word per
// triangle: the three normal components in m_tdata and the valid flag in
// m_tuser. A triangle whose cross product is zero (a zero edge, equal edges or
// collinear points) gives valid 0 and a zero normal.
// Components are truncated toward zero and their magnitude saturates at 32767.
// Throughput is one triangle per cycle while m_tready is high. A triangle passes
// through 22 register stages from the accepting edge to m_tvalid: three cross
// product stages, two squared length stages, sixteen root stages (one load stage
// and fifteen that settle one result bit each), and the output register.
// All stages move together. When the receiver holds m_tready low with a
// result waiting, the whole pipeline holds and s_tready drops; nothing is lost
// or repeated, and bubbles pass through freely while m_tvalid is low.
// Reset (rst, synchronous) empties the pipeline and clears m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal_unit #(
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  wire logic [143:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // norm_x, norm_y, norm_z from bit 0 up
  output logic [47:0]        m_tdata,
  // valid_res
  output logic [0:0]         m_tuser
);

  localparam int RW     = tun_pkg::rem_width(OUT_FRAC_BITS);
  localparam int PIPE   = 21;
  localparam int ROOT_D = tun_pkg::Q_W + 1;

  logic                              en;
  logic [PIPE-1:0]                   vld;
  logic [ROOT_D-1:0]                 nd;
  logic signed [tun_pkg::N_W-1:0]    n_x, n_y, n_z;
  logic [tun_pkg::LEN_W-1:0]         len2;
  logic [RW-1:0]                     t_x, t_y, t_z;
  logic [2:0]                        sgn;
  logic                              nondeg;
  logic [tun_pkg::Q_W-1:0]           q_x, q_y, q_z;
  logic                              s_x, s_y, s_z;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tun_cross u_cross (
    .clk (clk),
    .en  (en),
    .a_x (s_tdata[15:0]),
    .a_y (s_tdata[31:16]),
    .a_z (s_tdata[47:32]),
    .b_x (s_tdata[63:48]),
    .b_y (s_tdata[79:64]),
    .b_z (s_tdata[95:80]),
    .c_x (s_tdata[111:96]),
    .c_y (s_tdata[127:112]),
    .c_z (s_tdata[143:128]),
    .n_x (n_x),
    .n_y (n_y),
    .n_z (n_z)
  );

  tun_len #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_len (
    .clk    (clk),
    .en     (en),
    .n_x    (n_x),
    .n_y    (n_y),
    .n_z    (n_z),
    .len2   (len2),
    .t_x    (t_x),
    .t_y    (t_y),
    .t_z    (t_z),
    .sgn    (sgn),
    .nondeg (nondeg)
  );

  tun_root #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_root_x (
    .clk (clk), .en (en), .t (t_x), .len2 (len2), .sgn_in (sgn[0]),
    .q (q_x), .sgn_out (s_x)
  );

  tun_root #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_root_y (
    .clk (clk), .en (en), .t (t_y), .len2 (len2), .sgn_in (sgn[1]),
    .q (q_y), .sgn_out (s_y)
  );

  tun_root #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_root_z (
    .clk (clk), .en (en), .t (t_z), .len2 (len2), .sgn_in (sgn[2]),
    .q (q_z), .sgn_out (s_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[PIPE-2:0], s_tvalid};
      m_tvalid <= vld[PIPE-1];
    end
  end

  // The degenerate flag runs beside the root lanes; a zero length would
  // otherwise drive every lane to full scale.
  always_ff @(posedge clk) begin
    if (en) begin
      nd         <= {nd[ROOT_D-2:0], nondeg};
      m_tuser[0] <= nd[ROOT_D-1];
      m_tdata[15:0]  <= !nd[ROOT_D-1] ? '0 :
                        s_x ? -tun_pkg::OUT_W'(q_x) : tun_pkg::OUT_W'(q_x);
      m_tdata[31:16] <= !nd[ROOT_D-1] ? '0 :
                        s_y ? -tun_pkg::OUT_W'(q_y) : tun_pkg::OUT_W'(q_y);
      m_tdata[47:32] <= !nd[ROOT_D-1] ? '0 :
                        s_z ? -tun_pkg::OUT_W'(q_z) : tun_pkg::OUT_W'(q_z);
    end
  end

  a_ready_follows_output : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow the output register state");

  a_degenerate_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate triangle gave a nonzero normal");

  a_saturated : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000 &&
                 m_tdata[47:32] != 16'h8000)
    else $error("normal component outside the saturated range");

  a_empty_after_reset : assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result word shown right after reset");

endmodule

`default_nettype wire
